@@ sv/gpm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpm_pkg
// shared constants, payload types and the decoded command word
// ----------------------------------------------------------------------------
package gpm_pkg;

	localparam int GRAN_SHIFT   = 18;
	localparam int MAP_GRANULES = 4096;
	localparam int DIO_SHIFT    = 12;
	localparam int OFF_W        = 48;
	localparam int TAG_W        = 32;
	localparam int QDEPTH       = 2;

	localparam int IDX_W     = $clog2(MAP_GRANULES);
	localparam int CNT_W     = IDX_W + 1;
	localparam int BIT_W     = 6;
	localparam int WORD_W    = 64;
	localparam int MAP_WORDS = MAP_GRANULES / WORD_W;
	localparam int WIDX_W    = (IDX_W > BIT_W) ? IDX_W - BIT_W : 1;
	localparam int GIDX_W    = OFF_W - GRAN_SHIFT;
	localparam int GEND_W    = OFF_W + 1 - GRAN_SHIFT;
	localparam int BYTE_W    = IDX_W + GRAN_SHIFT + 1;
	localparam int NPOW      = IDX_W - BIT_W + 1;

	localparam logic [OFF_W-1:0] SIZE_LIMIT = OFF_W'(MAP_GRANULES) << GRAN_SHIFT;
	localparam logic [OFF_W-1:0] GRAN_BYTES = OFF_W'(1) << GRAN_SHIFT;
	localparam logic [CNT_W-1:0] MIN_GRAN   = CNT_W'(WORD_W);

	localparam logic [1:0] ACT_READ     = 2'd0;
	localparam logic [1:0] ACT_WRITE    = 2'd1;
	localparam logic [1:0] ACT_MARK     = 2'd2;
	localparam logic [1:0] ACT_SHORTEN  = 2'd3;

	localparam logic [1:0] SRC_SERVER = 2'd0;
	localparam logic [1:0] SRC_ZERO   = 2'd1;
	localparam logic [1:0] SRC_CACHE  = 2'd2;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SERVER_EOF = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_INVAL      = 1'b1;

	typedef struct packed {
		logic [1:0]       action;
		logic [OFF_W-1:0] start_req;
		logic [OFF_W-1:0] length;
		logic [OFF_W-1:0] file_size;
		logic [TAG_W-1:0] inval_tag;
	} gpm_in_t;

	typedef struct packed {
		logic [1:0]       source;
		logic             write_to_cache;
		logic [OFF_W-1:0] out_start;
		logic [OFF_W-1:0] out_length;
		logic             no_space;
	} gpm_out_t;

	typedef struct packed {
		gpm_in_t           item;
		logic              beyond;
		logic [BYTE_W-1:0] lenc;
		logic [GIDX_W-1:0] gidx;
		logic [CNT_W-1:0]  need;
		logic [GEND_W-1:0] glast;
		logic [GEND_W-1:0] keep;
	} gpm_cmd_t;

endpackage

@@ sv/gpm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpm_front
// accepts request words and precomputes the item-local quantities
// ----------------------------------------------------------------------------
module gpm_front (
	input  logic           in_valid,
	output logic           in_ready,
	input  gpm_pkg::gpm_in_t in_data,
	input  logic           q_full,
	output logic           q_push,
	output gpm_pkg::gpm_cmd_t q_data
);
	import gpm_pkg::*;

	logic [OFF_W-1:0]  room;
	logic [OFF_W:0]    size;
	logic [OFF_W:0]    end_m1;
	logic [CNT_W-1:0]  gran;
	logic [CNT_W-1:0]  bits;
	logic [CNT_W-1:0]  need;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		room = SIZE_LIMIT - in_data.start_req;
		size = {1'b0, in_data.file_size} + {1'b0, GRAN_BYTES} - (OFF_W+1)'(1);
		if (size > {1'b0, SIZE_LIMIT}) begin
			size = {1'b0, SIZE_LIMIT};
		end
		gran = CNT_W'(size >> GRAN_SHIFT);
		bits = (gran + CNT_W'(WORD_W - 1)) & ~CNT_W'(WORD_W - 1);
		need = CNT_W'(MAP_GRANULES);
		for (int i = NPOW - 1; i >= 0; i--) begin
			if (bits <= (MIN_GRAN << i)) begin
				need = MIN_GRAN << i;
			end
		end
		if (in_data.file_size <= (GRAN_BYTES << BIT_W)) begin
			need = MIN_GRAN;
		end
		end_m1 = {1'b0, in_data.start_req} + {1'b0, in_data.length} - (OFF_W+1)'(1);

		q_data.item   = in_data;
		q_data.beyond = in_data.start_req >= SIZE_LIMIT;
		q_data.lenc   = (in_data.length > room) ? room[BYTE_W-1:0]
			: in_data.length[BYTE_W-1:0];
		q_data.gidx   = in_data.start_req[OFF_W-1:GRAN_SHIFT];
		q_data.need   = need;
		q_data.glast  = (in_data.length == '0) ? GEND_W'(in_data.start_req[OFF_W-1:GRAN_SHIFT])
			: end_m1[OFF_W:GRAN_SHIFT];
		q_data.keep   = GEND_W'(({1'b0, in_data.file_size} + {1'b0, GRAN_BYTES}
			- (OFF_W+1)'(1)) >> GRAN_SHIFT);
	end

endmodule

@@ sv/gpm_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpm_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module gpm_queue #(
	parameter int DEPTH = gpm_pkg::QDEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gpm_pkg::gpm_cmd_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output gpm_pkg::gpm_cmd_t pop_data
);
	import gpm_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	gpm_cmd_t             slot_q [DEPTH];
	logic [PTR_W-1:0]     wr_q;
	logic [PTR_W-1:0]     rd_q;
	logic [PTR_W:0]       cnt_q;

	assign full     = cnt_q == (PTR_W+1)'(DEPTH);
	assign valid    = cnt_q != '0;
	assign pop_data = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

endmodule

@@ sv/gpm_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpm_back
// owns the presence map and map state, scans words and drives the result
// ----------------------------------------------------------------------------
module gpm_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gpm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gpm_pkg::OFF_W-1:0]         cfg_data,
	input  logic                              q_valid,
	input  gpm_pkg::gpm_cmd_t                 q_data,
	output logic                              q_pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output gpm_pkg::gpm_out_t                 out_data
);
	import gpm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_CLASS, S_FETCH, S_BIT, S_SCAN, S_RFIN, S_MARK, S_TRUNC
	} state_t;

	state_t                 state_q;
	state_t                 ret_q;
	gpm_cmd_t               cmd_q;
	logic [CNT_W-1:0]       active_q;
	logic [OFF_W-1:0]       zp_q;
	logic [TAG_W-1:0]       inval_q;
	logic [MAP_WORDS-1:0]   vld_q;
	logic                   rvld_q;
	logic [WORD_W-1:0]      rdata_q;
	logic [WIDX_W-1:0]      widx_q;
	logic [IDX_W-1:0]       lo_q;
	logic [IDX_W-1:0]       hi_q;
	logic                   want_q;
	logic [1:0]             src_q;
	logic                   wtc_q;
	logic [CNT_W-1:0]       next_q;
	logic                   out_valid_q;
	gpm_out_t               out_q;
	logic [WORD_W-1:0]      mem [MAP_WORDS];

	logic [WORD_W-1:0]      rd_word;
	logic [WORD_W-1:0]      hit;
	logic [WORD_W-1:0]      mark_mask;
	logic [WORD_W-1:0]      wdata;
	logic                   mem_we;
	logic [BIT_W-1:0]       ffs;
	logic                   grow;
	logic [CNT_W-1:0]       a_new;
	logic                   in_map;
	logic [BYTE_W-1:0]      limitb;
	logic [BYTE_W-1:0]      wroom;
	logic [BYTE_W-1:0]      wlen;
	logic [BYTE_W:0]        wsum;
	logic [BYTE_W-1:0]      cand;
	logic [GEND_W-1:0]      act_m1;
	logic                   start_ge_zp;
	logic [BIT_W-1:0]       lo_b;
	logic [BIT_W-1:0]       hi_b;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign q_pop     = (state_q == S_IDLE) && q_valid && !out_valid_q;

	always_comb begin
		rd_word = rvld_q ? rdata_q : '0;
		hit = want_q ? rd_word : ~rd_word;
		if (widx_q == lo_q[IDX_W-1:BIT_W]) begin
			hit = hit & ((~WORD_W'(0) << lo_q[BIT_W-1:0]) << 1);
		end
		ffs = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (hit[i]) begin
				ffs = BIT_W'(i);
			end
		end
		lo_b = (widx_q == lo_q[IDX_W-1:BIT_W]) ? lo_q[BIT_W-1:0] : '0;
		hi_b = (widx_q == hi_q[IDX_W-1:BIT_W]) ? hi_q[BIT_W-1:0] : '1;
		mark_mask = (~WORD_W'(0) << lo_b) & (~WORD_W'(0) >> (BIT_W'(WORD_W - 1) - hi_b));
		mem_we = (state_q == S_MARK) || (state_q == S_TRUNC);
		if (state_q == S_MARK) begin
			wdata = rd_word | mark_mask;
		end else begin
			wdata = rd_word & ~(~WORD_W'(0) << cmd_q.keep[BIT_W-1:0]);
		end

		grow   = !cmd_q.beyond && (cmd_q.gidx >= GIDX_W'(active_q))
			&& (cmd_q.need > active_q);
		a_new  = grow ? cmd_q.need : active_q;
		in_map = !cmd_q.beyond && (cmd_q.gidx < GIDX_W'(a_new));
		limitb = BYTE_W'(a_new) << GRAN_SHIFT;
		wroom  = limitb - cmd_q.item.start_req[BYTE_W-1:0];
		wlen   = (cmd_q.item.length > OFF_W'(wroom)) ? wroom
			: cmd_q.item.length[BYTE_W-1:0];
		wsum   = (BYTE_W+1)'(cmd_q.item.start_req[DIO_SHIFT-1:0]) + (BYTE_W+1)'(wlen)
			+ (BYTE_W+1)'((1 << DIO_SHIFT) - 1);
		wsum   = wsum & ~(BYTE_W+1)'((1 << DIO_SHIFT) - 1);
		cand   = (BYTE_W'(next_q) << GRAN_SHIFT) - cmd_q.item.start_req[BYTE_W-1:0];
		act_m1 = GEND_W'(active_q) - GEND_W'(1);
		start_ge_zp = cmd_q.item.start_req >= zp_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[widx_q] <= wdata;
		end
		rdata_q <= mem[widx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			cmd_q       <= '0;
			active_q    <= MIN_GRAN;
			zp_q        <= '0;
			inval_q     <= '0;
			vld_q       <= '0;
			rvld_q      <= 1'b0;
			widx_q      <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			want_q      <= 1'b0;
			src_q       <= SRC_SERVER;
			wtc_q       <= 1'b0;
			next_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			rvld_q <= vld_q[widx_q];
			if (mem_we) begin
				vld_q[widx_q] <= 1'b1;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_SERVER_EOF: zp_q <= cfg_data;
					CFG_INVAL:      inval_q <= cfg_data[TAG_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						cmd_q   <= q_data;
						out_q   <= '0;
						state_q <= S_CLASS;
					end
				end
				S_CLASS: begin
					state_q <= S_IDLE;
					case (cmd_q.item.action)
						ACT_READ: begin
							active_q <= a_new;
							out_q.out_start <= cmd_q.item.start_req;
							if (cmd_q.beyond) begin
								out_q.source <= (cmd_q.item.start_req >= cmd_q.item.file_size)
									? SRC_ZERO : SRC_SERVER;
								out_q.out_length <= cmd_q.item.length;
								out_valid_q <= 1'b1;
							end else if (!in_map) begin
								out_q.source <= start_ge_zp ? SRC_ZERO : SRC_SERVER;
								out_q.out_length <= OFF_W'(cmd_q.lenc);
								out_valid_q <= 1'b1;
							end else if (cmd_q.item.start_req >= cmd_q.item.file_size) begin
								out_q.source <= SRC_ZERO;
								out_q.write_to_cache <= 1'b1;
								out_q.out_length <= OFF_W'(cmd_q.lenc);
								out_valid_q <= 1'b1;
							end else begin
								lo_q    <= cmd_q.gidx[IDX_W-1:0];
								widx_q  <= cmd_q.gidx[IDX_W-1:BIT_W];
								ret_q   <= S_BIT;
								state_q <= S_FETCH;
							end
						end
						ACT_WRITE: begin
							active_q <= a_new;
							if (!in_map) begin
								out_q.no_space   <= 1'b1;
								out_q.out_start  <= cmd_q.item.start_req;
								out_q.out_length <= cmd_q.item.length;
							end else begin
								out_q.out_start <= cmd_q.item.start_req
									& ~OFF_W'((1 << DIO_SHIFT) - 1);
								out_q.out_length <= OFF_W'(wsum);
							end
							out_valid_q <= 1'b1;
						end
						ACT_MARK: begin
							if ((cmd_q.item.inval_tag == inval_q)
								&& (cmd_q.gidx < GIDX_W'(active_q))) begin
								lo_q    <= cmd_q.gidx[IDX_W-1:0];
								hi_q    <= (cmd_q.glast < act_m1) ? cmd_q.glast[IDX_W-1:0]
									: act_m1[IDX_W-1:0];
								widx_q  <= cmd_q.gidx[IDX_W-1:BIT_W];
								ret_q   <= S_MARK;
								state_q <= S_FETCH;
							end else begin
								out_valid_q <= 1'b1;
							end
						end
						default: begin
							if (zp_q > cmd_q.item.file_size) begin
								zp_q <= cmd_q.item.file_size;
							end
							for (int w = 0; w < MAP_WORDS; w++) begin
								if ((GEND_W'(w) << BIT_W) >= cmd_q.keep) begin
									vld_q[w] <= 1'b0;
								end
							end
							if ((cmd_q.keep[BIT_W-1:0] != '0)
								&& ((cmd_q.keep >> BIT_W) < GEND_W'(MAP_WORDS))) begin
								widx_q  <= cmd_q.keep[BIT_W +: WIDX_W];
								ret_q   <= S_TRUNC;
								state_q <= S_FETCH;
							end else begin
								out_valid_q <= 1'b1;
							end
						end
					endcase
				end
				S_FETCH: begin
					state_q <= ret_q;
				end
				S_BIT: begin
					if (rd_word[lo_q[BIT_W-1:0]]
						&& (cmd_q.item.start_req[DIO_SHIFT-1:0] != '0)) begin
						out_q.source <= start_ge_zp ? SRC_ZERO : SRC_SERVER;
						out_q.write_to_cache <= 1'b1;
						out_q.out_length <= OFF_W'(cmd_q.lenc
							& BYTE_W'((1 << DIO_SHIFT) - 1));
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						want_q  <= !rd_word[lo_q[BIT_W-1:0]];
						src_q   <= rd_word[lo_q[BIT_W-1:0]] ? SRC_CACHE
							: (start_ge_zp ? SRC_ZERO : SRC_SERVER);
						wtc_q   <= !rd_word[lo_q[BIT_W-1:0]];
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit != '0) begin
						next_q  <= {1'b0, widx_q, ffs};
						state_q <= S_RFIN;
					end else if ((CNT_W'(widx_q) + CNT_W'(1)) >= (active_q >> BIT_W)) begin
						next_q  <= active_q;
						state_q <= S_RFIN;
					end else begin
						widx_q  <= widx_q + WIDX_W'(1);
						ret_q   <= S_SCAN;
						state_q <= S_FETCH;
					end
				end
				S_RFIN: begin
					out_q.source <= src_q;
					out_q.write_to_cache <= wtc_q;
					out_q.out_length <= OFF_W'((cmd_q.lenc > cand) ? cand : cmd_q.lenc);
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_MARK: begin
					if (widx_q == hi_q[IDX_W-1:BIT_W]) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						widx_q  <= widx_q + WIDX_W'(1);
						ret_q   <= S_MARK;
						state_q <= S_FETCH;
					end
				end
				S_TRUNC: begin
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ sv/granule_presence_map_read_planner_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// granule_presence_map_read_planner_core
// granule presence map with read and write planning, marking and shortening
// ----------------------------------------------------------------------------
// write plans and simple reads: the result word is set in the class state after the pop
// read scans and marks visit one 64-granule map word at a time, each through a
// fetch state and then the scan or mark state; a read scan ends in a final state
// the back runs one word at a time; a 2-deep queue lets the front keep accepting
// reset: map reads as empty at once through per-word valid flags, no sweep
module granule_presence_map_read_planner_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gpm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gpm_pkg::OFF_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  gpm_pkg::gpm_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output gpm_pkg::gpm_out_t             out_data
);
	import gpm_pkg::*;

	gpm_cmd_t push_data;
	gpm_cmd_t pop_data;
	logic     push;
	logic     full;
	logic     pop;
	logic     qv;

	gpm_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (full),
		.q_push   (push),
		.q_data   (push_data)
	);

	gpm_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.valid     (qv),
		.pop_data  (pop_data)
	);

	gpm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (qv),
		.q_data    (pop_data),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ tb/sv/tb_granule_presence_map_read_planner_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_granule_presence_map_read_planner_core
// Self-checking bench for the granule presence map planner. A scoreboard
// keeps its own copy of the map, active size, zero point and registers and
// predicts one result word per request. Directed requests come first, then
// random traffic, over several register settings, with random idling on
// both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_granule_presence_map_read_planner_core;
	import gpm_pkg::*;

	localparam longint unsigned F48      = 64'hFFFF_FFFF_FFFF;
	localparam longint unsigned LIMIT_B  = longint'(MAP_GRANULES) << GRAN_SHIFT;
	localparam longint unsigned GRAN_B   = 64'd1 << GRAN_SHIFT;
	localparam longint unsigned DIO_MASK = (64'd1 << DIO_SHIFT) - 1;

	class plan_scoreboard;
		bit present[MAP_GRANULES];
		int unsigned active;
		longint unsigned zero_pt;
		logic [TAG_W-1:0] inval;
		gpm_out_t plan_q[$];
		int errors;

		function new();
			foreach (present[i]) present[i] = 1'b0;
			active = 64;
			zero_pt = 0;
			inval = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [OFF_W-1:0] val);
			if (idx == CFG_SERVER_EOF) begin
				zero_pt = 64'(val);
			end else begin
				inval = val[TAG_W-1:0];
			end
		endfunction

		function bit hit(longint unsigned g);
			return g < active && present[g];
		endfunction

		function void grow(longint unsigned fs);
			longint unsigned sz, gr, p;
			if (fs <= GRAN_B * 64) p = 64;
			else begin
				sz = fs + GRAN_B - 1;
				if (sz > LIMIT_B) sz = LIMIT_B;
				gr = sz >> GRAN_SHIFT;
				gr = (gr + 63) & ~64'd63;
				p = 64;
				while (p < gr) p = p << 1;
				if (p > MAP_GRANULES) p = MAP_GRANULES;
			end
			if (p > active) active = 32'(p);
		endfunction

		function longint unsigned scan(longint unsigned from, bit want);
			longint unsigned g;
			for (g = from; g < active; g++)
				if (hit(g) == want) return g;
			return active;
		endfunction

		function void note_input(gpm_in_t it);
			longint unsigned st, ln, fs, g, nx, lim, dn, fin, keep;
			gpm_out_t r;
			st = it.start_req;
			ln = it.length;
			fs = it.file_size;
			r = '0;
			case (it.action)
				ACT_READ: begin
					r.out_start = OFF_W'(st);
					if (st >= LIMIT_B) begin
						r.source = (st >= fs) ? SRC_ZERO : SRC_SERVER;
					end else begin
						if (ln > LIMIT_B - st) ln = LIMIT_B - st;
						g = st >> GRAN_SHIFT;
						if (g >= active) grow(fs);
						if (g >= active) begin
							r.source = (st >= zero_pt) ? SRC_ZERO : SRC_SERVER;
						end else if (st >= fs) begin
							r.source = SRC_ZERO;
							r.write_to_cache = 1'b1;
						end else if (hit(g)) begin
							if (st & DIO_MASK) begin
								ln = ln & DIO_MASK;
								r.source = (st >= zero_pt) ? SRC_ZERO : SRC_SERVER;
								r.write_to_cache = 1'b1;
							end else begin
								nx = scan(g + 1, 1'b0);
								if (ln > (nx << GRAN_SHIFT) - st) ln = (nx << GRAN_SHIFT) - st;
								r.source = SRC_CACHE;
							end
						end else begin
							nx = scan(g + 1, 1'b1);
							if (ln > (nx << GRAN_SHIFT) - st) ln = (nx << GRAN_SHIFT) - st;
							r.source = (st >= zero_pt) ? SRC_ZERO : SRC_SERVER;
							r.write_to_cache = 1'b1;
						end
					end
					r.out_length = OFF_W'(ln);
				end
				ACT_WRITE: begin
					bit ok;
					g = st >> GRAN_SHIFT;
					ok = st < LIMIT_B;
					if (ok && g >= active) begin
						grow(fs);
						if (g >= active) ok = 1'b0;
					end
					lim = longint'(active) << GRAN_SHIFT;
					if (ok && st >= lim) ok = 1'b0;
					if (!ok) begin
						r.no_space = 1'b1;
						r.out_start = OFF_W'(st);
						r.out_length = OFF_W'(ln);
					end else begin
						if (ln > lim - st) ln = lim - st;
						dn = st & DIO_MASK;
						r.out_start = OFF_W'(st - dn);
						r.out_length = OFF_W'((dn + ln + DIO_MASK) & ~DIO_MASK);
					end
				end
				ACT_MARK: begin
					if (it.inval_tag == inval) begin
						fin = st + ln;
						g = st >> GRAN_SHIFT;
						do begin
							if (g >= active) break;
							present[g] = 1'b1;
							g++;
						end while ((g << GRAN_SHIFT) < fin);
					end
				end
				default: begin
					keep = (fs + GRAN_B - 1) >> GRAN_SHIFT;
					if (zero_pt > fs) zero_pt = fs;
					foreach (present[i])
						if (i >= keep) present[i] = 1'b0;
				end
			endcase
			plan_q.push_back(r);
		endfunction

		function void cmp(string fld, longint unsigned e, longint unsigned a);
			if (e != a) begin
				$display("%0t mismatch %s expected %h actual %h", $time, fld, e, a);
				errors++;
			end
		endfunction

		function void check_result(gpm_out_t a);
			gpm_out_t e;
			if (plan_q.size() == 0) begin
				$display("%0t unexpected word actual %h", $time, a);
				errors++;
				return;
			end
			e = plan_q.pop_front();
			cmp("source", e.source, a.source);
			cmp("write_to_cache", e.write_to_cache, a.write_to_cache);
			cmp("out_start", e.out_start, a.out_start);
			cmp("out_length", e.out_length, a.out_length);
			cmp("no_space", e.no_space, a.no_space);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [OFF_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	gpm_in_t in_data;
	logic out_valid;
	logic out_ready;
	gpm_out_t out_data;

	plan_scoreboard sb = new();
	bit calm;
	bit hold_go;
	int unsigned rx_cycles;

	granule_presence_map_read_planner_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) sb.note_input(in_data);
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
	end

	// receiver, with one long hold-off so the input side backs up
	initial begin
		out_ready = 1'b0;
		rx_cycles = 0;
		forever begin
			@(posedge clk);
			if (hold_go && rx_cycles < 600) begin
				rx_cycles++;
				out_ready <= 1'b0;
			end
			else if (calm) out_ready <= 1'b1;
			else out_ready <= ($urandom_range(0, 99) >= 20);
		end
	end

	function automatic logic [OFF_W-1:0] pick_off();
		case ($urandom_range(0, 9))
			0, 1, 2: return OFF_W'((OFF_W'($urandom_range(0, 140)) << GRAN_SHIFT) |
				(($urandom_range(0, 2) == 0) ? '0 : OFF_W'($urandom) & OFF_W'(GRAN_B - 1)));
			3: return OFF_W'($urandom_range(0, 4200)) << GRAN_SHIFT;
			4: return OFF_W'(LIMIT_B) + OFF_W'($urandom_range(0, 20)) - OFF_W'(10);
			5: return OFF_W'({$urandom, $urandom});
			6: return '0;
			7: return OFF_W'(F48);
			default: return OFF_W'($urandom_range(0, 3000000));
		endcase
	endfunction

	function automatic gpm_in_t make_req(logic [1:0] act, longint unsigned st,
			longint unsigned ln, longint unsigned fs, logic [TAG_W-1:0] tg);
		gpm_in_t it;
		it.action = act;
		it.start_req = OFF_W'(st);
		it.length = OFF_W'(ln);
		it.file_size = OFF_W'(fs);
		it.inval_tag = tg;
		return it;
	endfunction

	task automatic send_word(gpm_in_t it);
		if (!calm && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.plan_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [OFF_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic random_req();
		gpm_in_t it;
		int k;
		k = $urandom_range(0, 99);
		it.start_req = pick_off();
		it.length = pick_off();
		it.file_size = pick_off();
		it.inval_tag = ($urandom_range(0, 3) == 0) ? TAG_W'($urandom) : sb.inval;
		if (k < 40) it.action = ACT_READ;
		else if (k < 60) it.action = ACT_WRITE;
		else if (k < 94) it.action = ACT_MARK;
		else it.action = ACT_SHORTEN;
		send_word(it);
	endtask

	initial begin
		logic [OFF_W-1:0] eofs[5];
		logic [TAG_W-1:0] tags[5];
		logic [TAG_W-1:0] t;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		calm = 1'b0;
		hold_go = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		t = '0;
		send_word(make_req(ACT_READ, 0, GRAN_B * 3, GRAN_B * 10, t));
		send_word(make_req(ACT_WRITE, 12345, 7000, GRAN_B * 10, t));
		send_word(make_req(ACT_WRITE, LIMIT_B, 100, F48, t));
		send_word(make_req(ACT_READ, LIMIT_B + 5, 100, LIMIT_B, t));
		send_word(make_req(ACT_READ, LIMIT_B + 5, 100, F48, t));
		send_word(make_req(ACT_MARK, GRAN_B * 5 + 7, 0, 0, t));
		send_word(make_req(ACT_MARK, GRAN_B * 6, GRAN_B * 3, 0, t));
		send_word(make_req(ACT_READ, GRAN_B * 5, F48, F48, t));
		send_word(make_req(ACT_READ, GRAN_B * 5 + 100, F48, F48, t));
		send_word(make_req(ACT_READ, GRAN_B * 2, F48, F48, t));
		send_word(make_req(ACT_MARK, GRAN_B * 20, GRAN_B, 0, ~t));
		send_word(make_req(ACT_READ, GRAN_B * 20, GRAN_B, F48, t));
		send_word(make_req(ACT_READ, GRAN_B * 100, GRAN_B, GRAN_B * 300, t));
		send_word(make_req(ACT_WRITE, GRAN_B * 1000, 9, GRAN_B * 10, t));
		send_word(make_req(ACT_WRITE, GRAN_B * 1000 + 1, F48, F48, t));
		send_word(make_req(ACT_READ, GRAN_B * 8, GRAN_B, GRAN_B * 8, t));
		send_word(make_req(ACT_MARK, 0, F48, 0, t));
		send_word(make_req(ACT_READ, 0, F48, F48, t));
		send_word(make_req(ACT_SHORTEN, 0, 0, GRAN_B * 70 + 1, t));
		send_word(make_req(ACT_READ, F48, F48, F48, t));
		send_word(make_req(ACT_SHORTEN, F48, F48, 0, ~t));
		send_word(make_req(ACT_READ, 0, 0, 0, t));
		drain();

		eofs = '{OFF_W'(0), OFF_W'(F48), OFF_W'(GRAN_B * 40 + 123),
			OFF_W'({$urandom, $urandom}), OFF_W'(GRAN_B * 3)};
		tags = '{TAG_W'(0), '1, TAG_W'($urandom), TAG_W'(5), TAG_W'($urandom)};
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(CFG_SERVER_EOF, eofs[ph]);
			write_reg(CFG_INVAL, tags[ph]);
			for (int n = 0; n < 170; n++) begin
				calm = (ph == 2 && n >= 40 && n < 120);
				if (ph == 1 && n == 60) hold_go = 1'b1;
				random_req();
			end
			calm = 1'b0;
			drain();
		end

		if (sb.errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
sv/gpm_pkg.sv
sv/gpm_front.sv
sv/gpm_queue.sv
sv/gpm_back.sv
sv/granule_presence_map_read_planner_core.sv
tb/sv/tb_granule_presence_map_read_planner_core.sv
